// ===== hdl/scst_pkg.sv =====
// Shared types and constants of the S-curve speed table.
// No dependencies; every other file of the block imports this package.
package scst_pkg;

  localparam int unsigned SPEED_W      = 16;
  localparam int unsigned DUR_W        = 24;
  localparam int unsigned IDX_W        = 11;
  localparam int unsigned OUT_W        = 24;
  localparam int unsigned TOTAL_W      = 11;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;

  localparam int unsigned Q_W          = 24;
  localparam int unsigned FRAC_W       = 8;
  localparam int unsigned RAW_PROD_W   = SPEED_W + DUR_W;
  localparam int unsigned DIV_REM_W    = 23;
  localparam int unsigned HALF_RAW_W   = 18;
  localparam int unsigned HALF_FULL_W  = HALF_RAW_W + 1;
  localparam int unsigned TOTAL_FULL_W = HALF_FULL_W + 1;

  // Six million is 2^7 times 46875; the rounded-up reciprocal of 46875 scaled by 2^47
  // gives the exact quotient for every 32-bit dividend.
  localparam int unsigned SIXTH_SHIFT  = 7;
  localparam int unsigned SCALED_W     = 32;
  localparam int unsigned RECIP_W      = 32;
  localparam int unsigned RECIP_PROD_W = SCALED_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT  = 47;
  localparam logic [RECIP_W-1:0] SIXTH_RECIP = 32'd3002399752;

  localparam logic [DIV_REM_W-1:0] US_PER_SIXTH = DIV_REM_W'(6000000);
  localparam logic [TOTAL_W-1:0]   TOTAL_SAT    = '1;

  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_US = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  localparam logic [SPEED_W-1:0] START_SPEED_RST = '0;
  localparam logic [SPEED_W-1:0] END_SPEED_RST   = '0;
  localparam logic [DUR_W-1:0]   DURATION_RST    = DUR_W'(1000000);

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_FIN
  } cfg_state_t;

  typedef struct packed {
    logic [SPEED_W-1:0]      start_speed;
    logic [SPEED_W-1:0]      end_speed;
    logic [SPEED_W-1:0]      mag;
    logic                    delta_neg;
    logic [HALF_FULL_W-1:0]  half;
    logic [TOTAL_FULL_W-1:0] total;
    logic [TOTAL_W-1:0]      total_sat;
    logic                    too_long;
    logic                    half_zero;
  } scst_ramp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                neg;
    logic [SPEED_W-1:0]  base;
  } scst_side_t;

endpackage

// ===== hdl/scst_if.sv =====
// Handshake channels of the S-curve speed table: request in, result out, register write.
// Depends on scst_pkg for the field widths.
interface scst_in_if import scst_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] step_index;

  modport source (output valid, output step_index, input ready);
  modport sink (input valid, input step_index, output ready);
endinterface

interface scst_out_if import scst_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OUT_W-1:0]    speed_q8;
  logic [TOTAL_W-1:0]  total_steps;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output speed_q8, output total_steps, output status,
                  input ready);
  modport sink (input valid, input speed_q8, input total_steps, input status,
                output ready);
endinterface

interface scst_cfg_if import scst_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/scst_cfg.sv =====
// Configuration registers and the derivation of the ramp shape from them.
// Depends on scst_pkg and scst_cfg_if.
module scst_cfg import scst_pkg::*; #(
  parameter int unsigned MAX_STEPS = 1024,
  localparam int unsigned HALF_W = $clog2(MAX_STEPS / 2 + 1),
  localparam int unsigned NN_W = 2 * HALF_W
) (
  input  logic        clk,
  input  logic        rst_n,
  scst_cfg_if.sink    cfg_ch,
  output scst_ramp_t  ramp,
  output logic [NN_W-1:0] nn,
  output logic        busy
);

  cfg_state_t state_r, state_nxt;

  logic [SPEED_W-1:0] start_r, end_r;
  logic [DUR_W-1:0]   dur_r;
  logic               wr;

  logic [SPEED_W-1:0]      mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [SPEED_W:0]        sum;
  logic [SPEED_W-1:0]      mid;
  logic [RAW_PROD_W-1:0]   dvd_nxt;
  logic [SCALED_W-1:0]     scaled_r;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [HALF_RAW_W-1:0]   quo_r;

  logic [HALF_FULL_W-1:0]  half_nxt, half_r;
  logic [TOTAL_FULL_W-1:0] total_nxt, total_r;
  logic [TOTAL_W-1:0]      total_sat_r;
  logic                    too_long_r;
  logic                    half_zero_r;
  logic [HALF_W-1:0]       half_t;
  logic [NN_W-1:0]         nn_r;

  logic ld_mul, do_div, ld_fin;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_SPEED_RST;
      end_r   <= END_SPEED_RST;
      dur_r   <= DURATION_RST;
    end else if (wr) begin
      case (cfg_ch.index)
        REG_START_SPEED: start_r <= cfg_ch.data[SPEED_W-1:0];
        REG_END_SPEED:   end_r   <= cfg_ch.data[SPEED_W-1:0];
        REG_DURATION_US: dur_r   <= cfg_ch.data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: state_nxt = CS_IDLE;
      CS_MUL:  state_nxt = CS_DIV;
      CS_DIV:  state_nxt = CS_FIN;
      CS_FIN:  state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
    if (wr) state_nxt = CS_MUL;
  end

  always_comb begin
    busy   = 1'b1;
    ld_mul = 1'b0;
    do_div = 1'b0;
    ld_fin = 1'b0;
    case (state_r)
      CS_IDLE: busy = 1'b0;
      CS_MUL:  ld_mul = 1'b1;
      CS_DIV:  do_div = 1'b1;
      CS_FIN:  ld_fin = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CS_MUL;
    else        state_r <= state_nxt;
  end

  assign sum     = {1'b0, start_r} + {1'b0, end_r};
  assign mid     = sum[SPEED_W:1];
  assign neg_nxt = mid < start_r;
  assign mag_nxt = neg_nxt ? start_r - mid : mid - start_r;

  assign dvd_nxt    = RAW_PROD_W'(mag_nxt) * RAW_PROD_W'(dur_r);
  assign recip_prod = RECIP_PROD_W'(scaled_r) * RECIP_PROD_W'(SIXTH_RECIP);

  assign half_nxt  = {1'b0, quo_r} + HALF_FULL_W'(quo_r[0]);
  assign total_nxt = {half_nxt, 1'b0};
  assign half_t    = half_nxt[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      scaled_r <= dvd_nxt[SIXTH_SHIFT +: SCALED_W];
    end
    if (do_div) begin
      quo_r <= HALF_RAW_W'(recip_prod >> RECIP_SHIFT);
    end
    if (ld_fin) begin
      half_r      <= half_nxt;
      total_r     <= total_nxt;
      total_sat_r <= (total_nxt > TOTAL_FULL_W'(TOTAL_SAT)) ? TOTAL_SAT
                                                            : total_nxt[TOTAL_W-1:0];
      too_long_r  <= 32'(total_nxt) > 32'(MAX_STEPS);
      half_zero_r <= half_nxt == '0;
      nn_r        <= NN_W'(half_t * half_t);
    end
  end

  always_comb begin
    ramp.start_speed = start_r;
    ramp.end_speed   = end_r;
    ramp.mag         = mag_r;
    ramp.delta_neg   = neg_r;
    ramp.half        = half_r;
    ramp.total       = total_r;
    ramp.total_sat   = total_sat_r;
    ramp.too_long    = too_long_r;
    ramp.half_zero   = half_zero_r;
  end

  assign nn = nn_r;

  a_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> state_r == CS_MUL)
    else $error("register write did not restart the ramp derivation");

endmodule

// ===== hdl/s_curve_speed_table.sv =====
// Top level of the S-curve speed table: request and result channels and the divide pipeline.
// Depends on scst_pkg, scst_if and scst_cfg.
//
// One step index is taken per clock while the block is not busy and the result channel is ready;
// its result passes through these stages: one forms the distance from the nearer ramp end, one
// squares it, one scales it by half the speed change, 24 stages divide by the squared half length
// one quotient bit each, and one forms the output register. A stalled result channel holds the
// whole pipeline. After reset and after every register write the block takes no request while
// the half length is derived: the product of half the speed change and duration is formed, it is
// divided by six million as a multiplication by its reciprocal, and the half length is squared.
module s_curve_speed_table import scst_pkg::*; #(
  parameter int unsigned MAX_STEPS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  scst_in_if.sink    in_ch,
  scst_out_if.source out_ch,
  scst_cfg_if.sink   cfg_ch
);

  localparam int unsigned HALF_W = $clog2(MAX_STEPS / 2 + 1);
  localparam int unsigned NN_W   = 2 * HALF_W;
  localparam int unsigned PROD_W = SPEED_W + NN_W;
  localparam int unsigned NSTG   = 3 + Q_W;
  localparam int unsigned LAST   = NSTG - 1;

  scst_ramp_t        ramp;
  logic [NN_W-1:0]   nn;
  logic              busy;

  logic en, acc;

  logic                    valid_r [NSTG];
  scst_side_t              side_r  [NSTG];
  scst_side_t              side_nxt;
  logic [HALF_W-1:0]       d_r;
  logic [NN_W-1:0]         dsq_r;
  logic [PROD_W-1:0]       prod_r;
  logic [NN_W-1:0]         drem_r [Q_W];
  logic [Q_W-1:0]          dlow_r [Q_W];
  logic [Q_W-1:0]          dq_r   [Q_W];

  logic [TOTAL_FULL_W-1:0] idx_w, d_full;
  logic                    first;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_speed_r, speed_nxt;
  logic [TOTAL_W-1:0]      out_total_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [OUT_W-1:0]        base_q;
  logic [OUT_W:0]          corr, sum;

  scst_cfg #(.MAX_STEPS(MAX_STEPS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .ramp   (ramp),
    .nn     (nn),
    .busy   (busy)
  );

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && !busy;
  assign acc         = in_ch.valid && in_ch.ready;

  assign idx_w  = TOTAL_FULL_W'(in_ch.step_index);
  assign first  = idx_w <= TOTAL_FULL_W'(ramp.half);
  assign d_full = first ? idx_w : ramp.total - idx_w;

  always_comb begin
    side_nxt.neg  = first ? ramp.delta_neg : !ramp.delta_neg;
    side_nxt.base = first ? ramp.start_speed : ramp.end_speed;
    if (ramp.too_long)          side_nxt.status = ST_TOO_LONG;
    else if (idx_w > ramp.total) side_nxt.status = ST_BEYOND;
    else                        side_nxt.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) valid_r[s] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= acc;
      for (int s = 1; s < NSTG; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < NSTG; s++) side_r[s] <= side_r[s-1];
      d_r    <= d_full[HALF_W-1:0];
      dsq_r  <= NN_W'(d_r * d_r);
      prod_r <= PROD_W'(ramp.mag) * PROD_W'(dsq_r);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [NN_W-1:0] rem_in;
    logic [Q_W-1:0]  low_in;
    logic [Q_W-1:0]  q_in;
    logic [NN_W:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in = prod_r[PROD_W-1:SPEED_W];
      assign low_in = {prod_r[SPEED_W-1:0], {FRAC_W{1'b0}}};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = drem_r[k-1];
      assign low_in = dlow_r[k-1];
      assign q_in   = dq_r[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign take  = trial >= {1'b0, nn};

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k] <= take ? NN_W'(trial - {1'b0, nn}) : trial[NN_W-1:0];
        dlow_r[k] <= {low_in[Q_W-2:0], 1'b0};
        dq_r[k]   <= {q_in[Q_W-2:0], take};
      end
    end
  end

  assign base_q = {side_r[LAST].base, {FRAC_W{1'b0}}};
  assign corr   = {1'b0, dq_r[Q_W-1]} + (OUT_W + 1)'(drem_r[Q_W-1] != '0);
  assign sum    = side_r[LAST].neg ? {1'b0, base_q} - corr
                                   : {1'b0, base_q} + {1'b0, dq_r[Q_W-1]};

  always_comb begin
    if (side_r[LAST].status != ST_OK) speed_nxt = '0;
    else if (ramp.half_zero)          speed_nxt = base_q;
    else                              speed_nxt = sum[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_speed_r  <= speed_nxt;
      out_total_r  <= ramp.total_sat;
      out_status_r <= side_r[LAST].status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.speed_q8    = out_speed_r;
  assign out_ch.total_steps = out_total_r;
  assign out_ch.status      = out_status_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("request taken while the ramp is being derived");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_TOO_LONG || out_ch.status == ST_BEYOND))
      |-> out_ch.speed_q8 == '0)
    else $error("error result carries a nonzero speed");

  a_flat_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_OK && ramp.half_zero)
      |-> out_ch.speed_q8 == {ramp.start_speed, {FRAC_W{1'b0}}})
    else $error("zero-length ramp did not return the start speed");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> valid_r[LAST] == $past(valid_r[LAST]))
    else $error("pipeline moved while the result was stalled");

endmodule
